>>> sv/jsap_pkg.sv
package jsap_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_ACC   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // error codes
  localparam logic [3:0] ERR_END      = 4'd0;
  localparam logic [3:0] ERR_OPEN     = 4'd1;
  localparam logic [3:0] ERR_QUOTE    = 4'd2;
  localparam logic [3:0] ERR_SEP      = 4'd3;
  localparam logic [3:0] ERR_UNTERM   = 4'd4;
  localparam logic [3:0] ERR_ESCAPE   = 4'd5;
  localparam logic [3:0] ERR_SHORT_U  = 4'd6;
  localparam logic [3:0] ERR_HEX      = 4'd7;
  localparam logic [3:0] ERR_TRAILING = 4'd8;

  // input op codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // most results one input request can cause
  localparam int MAX_RES = 3;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [5:0] UTF_MASK  = 6'h3F;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] error_code;
    logic       last;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  // hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    hex_val = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      hex_val = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      hex_val = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      hex_val = {1'b1, d[3:0]};
    end
  endfunction

endpackage

>>> sv/json_string_array_parser.sv
// JSON string-array parser.
// Input channel (in_valid / in_stall): one request per cycle carries either a
// document byte (in_op = 0, in_data_byte) or an end-of-document marker
// (in_op = 1). Result channel (out_valid / out_stall): one result per cycle
// with out_kind, out_out_byte, out_error_code and out_last; out_last marks
// the final result of an input request.
// The first result of a request is visible the cycle after it is accepted if
// the result queue was empty. The input takes one request per cycle while
// requests yield at most one result each and the receiver keeps up. A \u
// escape whose last hex digit expands to two or three UTF-8 bytes pushes that
// many entries into the four-entry result queue, so input stalls while it
// drains.
// in_stall is driven from the queue fill level only, so it is registered
// with respect to out_stall.
// Reset: parser returns to waiting for '[' and the result queue empties.
// When the receiver stalls, results wait in the queue; once more than one
// result is pending the input stalls too. No result is dropped.
module json_string_array_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_out_byte,
  output logic [3:0] out_error_code,
  output logic       out_last
);

  typedef enum logic [2:0] {
    PH_OPEN, PH_ITEM, PH_STR, PH_ESC, PH_HEX, PH_SEP, PH_DONE, PH_FAIL
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      hex_count_r, hex_count_nxt;
  logic [15:0]     code_point_r, code_point_nxt;
  logic            accept;
  logic            busy;
  logic [1:0]      res_n;
  logic [1:0]      push_n;
  jsap_pkg::res_t  res [jsap_pkg::MAX_RES];
  jsap_pkg::res_t  head;
  logic [4:0]      hv;
  logic [15:0]     cp_new;
  logic [7:0]      c;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;
  assign push_n   = accept ? res_n : 2'd0;
  assign c        = in_data_byte;
  assign hv       = jsap_pkg::hex_val(c);
  assign cp_new   = {code_point_r[11:0], hv[3:0]};

  // parser step: next state and up to three results
  always_comb begin
    phase_nxt      = phase_r;
    hex_count_nxt  = hex_count_r;
    code_point_nxt = code_point_r;
    res_n          = 2'd0;
    for (int i = 0; i < jsap_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end

    if (in_op == jsap_pkg::OP_END) begin
      // end of document: report and rewind
      res_n         = 2'd1;
      res[0].kind   = jsap_pkg::KIND_ERR;
      unique case (phase_r)
        PH_DONE: res[0].kind       = jsap_pkg::KIND_ACC;
        PH_FAIL: res[0].error_code = code_point_r[3:0];
        PH_STR:  res[0].error_code = jsap_pkg::ERR_UNTERM;
        PH_ESC:  res[0].error_code = jsap_pkg::ERR_ESCAPE;
        PH_HEX:  res[0].error_code = jsap_pkg::ERR_SHORT_U;
        default: res[0].error_code = jsap_pkg::ERR_END;
      endcase
      phase_nxt      = PH_OPEN;
      hex_count_nxt  = 2'd0;
      code_point_nxt = 16'd0;
    end else begin
      unique case (phase_r)
        PH_OPEN: begin
          if (c == 8'h5B) begin
            phase_nxt = PH_ITEM;
          end else if (!jsap_pkg::is_ws(c)) begin
            res_n = 2'd1;
            res[0].kind = jsap_pkg::KIND_ERR;
            res[0].error_code = jsap_pkg::ERR_OPEN;
          end
        end
        PH_ITEM: begin
          if (c == 8'h5D) begin
            phase_nxt = PH_DONE;
          end else if (c == 8'h22) begin
            phase_nxt = PH_STR;
          end else if (!jsap_pkg::is_ws(c)) begin
            res_n = 2'd1;
            res[0].kind = jsap_pkg::KIND_ERR;
            res[0].error_code = jsap_pkg::ERR_QUOTE;
          end
        end
        PH_STR: begin
          res_n = 2'd1;
          if (c == 8'h22) begin
            phase_nxt = PH_SEP;
            res[0].kind = jsap_pkg::KIND_ENTRY;
          end else if (c == 8'h5C) begin
            phase_nxt = PH_ESC;
            res_n = 2'd0;
          end else begin
            res[0].kind = jsap_pkg::KIND_BYTE;
            res[0].data = c;
          end
        end
        PH_ESC: begin
          phase_nxt   = PH_STR;
          res_n       = 2'd1;
          res[0].kind = jsap_pkg::KIND_BYTE;
          case (c)
            8'h22: res[0].data = 8'h22;
            8'h5C: res[0].data = 8'h5C;
            8'h2F: res[0].data = 8'h2F;
            8'h62: res[0].data = 8'h08;
            8'h66: res[0].data = 8'h0C;
            8'h6E: res[0].data = 8'h0A;
            8'h72: res[0].data = 8'h0D;
            8'h74: res[0].data = 8'h09;
            8'h75: begin
              phase_nxt      = PH_HEX;
              hex_count_nxt  = 2'd0;
              code_point_nxt = 16'd0;
              res_n          = 2'd0;
            end
            default: begin
              res[0].kind       = jsap_pkg::KIND_ERR;
              res[0].error_code = jsap_pkg::ERR_ESCAPE;
            end
          endcase
        end
        PH_HEX: begin
          if (!hv[4]) begin
            res_n = 2'd1;
            res[0].kind = jsap_pkg::KIND_ERR;
            res[0].error_code = jsap_pkg::ERR_HEX;
          end else if (hex_count_r != 2'd3) begin
            hex_count_nxt  = hex_count_r + 2'd1;
            code_point_nxt = cp_new;
          end else begin
            // fourth digit: emit UTF-8 encoding
            phase_nxt      = PH_STR;
            hex_count_nxt  = 2'd0;
            code_point_nxt = 16'd0;
            res[0].kind    = jsap_pkg::KIND_BYTE;
            res[1].kind    = jsap_pkg::KIND_BYTE;
            res[2].kind    = jsap_pkg::KIND_BYTE;
            if (cp_new < 16'h0080) begin
              res_n       = 2'd1;
              res[0].data = cp_new[7:0];
            end else if (cp_new < 16'h0800) begin
              res_n       = 2'd2;
              res[0].data = jsap_pkg::UTF_LEAD2 | {3'b000, cp_new[10:6]};
              res[1].data = jsap_pkg::UTF_CONT | {2'b00, cp_new[5:0] & jsap_pkg::UTF_MASK};
            end else begin
              res_n       = 2'd3;
              res[0].data = jsap_pkg::UTF_LEAD3 | {4'h0, cp_new[15:12]};
              res[1].data = jsap_pkg::UTF_CONT | {2'b00, cp_new[11:6] & jsap_pkg::UTF_MASK};
              res[2].data = jsap_pkg::UTF_CONT | {2'b00, cp_new[5:0] & jsap_pkg::UTF_MASK};
            end
          end
        end
        PH_SEP: begin
          if (c == 8'h2C) begin
            phase_nxt = PH_ITEM;
          end else if (c == 8'h5D) begin
            phase_nxt = PH_DONE;
          end else if (!jsap_pkg::is_ws(c)) begin
            res_n = 2'd1;
            res[0].kind = jsap_pkg::KIND_ERR;
            res[0].error_code = jsap_pkg::ERR_SEP;
          end
        end
        PH_DONE: begin
          if (!jsap_pkg::is_ws(c)) begin
            res_n = 2'd1;
            res[0].kind = jsap_pkg::KIND_ERR;
            res[0].error_code = jsap_pkg::ERR_TRAILING;
          end
        end
        PH_FAIL: begin
          // silent until end of document
        end
        default: begin
        end
      endcase

      // any error on a byte moves to the failed phase, code kept in code_point
      if (res_n == 2'd1 && res[0].kind == jsap_pkg::KIND_ERR) begin
        phase_nxt      = PH_FAIL;
        hex_count_nxt  = 2'd0;
        code_point_nxt = {12'h000, res[0].error_code};
      end
    end

    // flag the final result of this request
    for (int i = 0; i < jsap_pkg::MAX_RES; i++) begin
      res[i].last = (res_n == 2'(i + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OPEN;
      hex_count_r  <= 2'd0;
      code_point_r <= 16'd0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      hex_count_r  <= hex_count_nxt;
      code_point_r <= code_point_nxt;
    end
  end

  // result queue
  jsap_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_data (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind       = head.kind;
  assign out_out_byte   = head.data;
  assign out_error_code = head.error_code;
  assign out_last       = head.last;

endmodule

>>> sv/jsap_res_fifo.sv
module jsap_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  jsap_pkg::res_t      push_data [jsap_pkg::MAX_RES],
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output jsap_pkg::res_t      head
);

  jsap_pkg::res_t mem_r [4];
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign head      = mem_r[rd_ptr_r];
  // a burst of three must always fit, so hold input while more than one waits
  assign busy      = (count_r > 3'd1);

  // pointer and fill count update
  always_comb begin
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    wr_ptr_nxt = wr_ptr_r + push_n;
    count_nxt  = count_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 2'd0;
      wr_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, up to three writes per cycle at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < jsap_pkg::MAX_RES; i++) begin
      if (2'(i) < push_n) begin
        mem_r[wr_ptr_r + 2'(i)] <= push_data[i];
      end
    end
  end

endmodule

>>> tb/json_string_array_parser_check.sv
`timescale 1ns / 1ps

// Watches both channels of the parser, predicts every result from the accepted
// requests and compares what comes out, in order, field by field.
module json_string_array_parser_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_data_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_out_byte,
  input  logic [3:0] out_error_code,
  input  logic       out_last,
  output int         mismatches,
  output int         results_due
);

  typedef enum logic [2:0] {
    P_OPEN, P_ITEM, P_STR, P_ESC, P_HEX, P_SEP, P_DONE, P_FAIL
  } parse_phase_t;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [3:0] NO_ERR    = 4'd0;

  // parser copy
  parse_phase_t phase;
  logic [1:0]   hex_seen;
  logic [15:0]  code_acc;

  jsap_pkg::res_t step_res[$];     // results of the request being decoded
  jsap_pkg::res_t parse_due[$];    // predicted results not yet seen on the output

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 'h30;
    if (c >= "a" && c <= "f") return int'(c) - 'h57;
    if (c >= "A" && c <= "F") return int'(c) - 'h37;
    return -1;
  endfunction

  function void queue_result(input logic [1:0] k, input logic [7:0] d, input logic [3:0] e);
    jsap_pkg::res_t r;
    r = {k, d, e, 1'b0};
    step_res.insert(step_res.size(), r);
  endfunction

  // first error: one error result, code kept for the end of the document
  function void enter_fail(input logic [3:0] e);
    phase = P_FAIL;
    hex_seen = 2'd0;
    code_acc = {12'd0, e};
    queue_result(jsap_pkg::KIND_ERR, 8'h00, e);
  endfunction

  // closing hex digit of \u: UTF-8 encode the collected code point
  function void emit_utf8(input logic [15:0] v);
    if (v < 16'h0080) begin
      queue_result(jsap_pkg::KIND_BYTE, v[7:0], NO_ERR);
    end else if (v < 16'h0800) begin
      queue_result(jsap_pkg::KIND_BYTE, jsap_pkg::UTF_LEAD2 | {3'b000, v[10:6]}, NO_ERR);
      queue_result(jsap_pkg::KIND_BYTE,
                   jsap_pkg::UTF_CONT | {2'b00, v[5:0] & jsap_pkg::UTF_MASK}, NO_ERR);
    end else begin
      queue_result(jsap_pkg::KIND_BYTE, jsap_pkg::UTF_LEAD3 | {4'b0000, v[15:12]}, NO_ERR);
      queue_result(jsap_pkg::KIND_BYTE,
                   jsap_pkg::UTF_CONT | {2'b00, v[11:6] & jsap_pkg::UTF_MASK}, NO_ERR);
      queue_result(jsap_pkg::KIND_BYTE,
                   jsap_pkg::UTF_CONT | {2'b00, v[5:0] & jsap_pkg::UTF_MASK}, NO_ERR);
    end
  endfunction

  function void end_document();
    case (phase)
      P_DONE:  queue_result(jsap_pkg::KIND_ACC, 8'h00, NO_ERR);
      P_FAIL:  queue_result(jsap_pkg::KIND_ERR, 8'h00, code_acc[3:0]);
      P_STR:   queue_result(jsap_pkg::KIND_ERR, 8'h00, jsap_pkg::ERR_UNTERM);
      P_ESC:   queue_result(jsap_pkg::KIND_ERR, 8'h00, jsap_pkg::ERR_ESCAPE);
      P_HEX:   queue_result(jsap_pkg::KIND_ERR, 8'h00, jsap_pkg::ERR_SHORT_U);
      default: queue_result(jsap_pkg::KIND_ERR, 8'h00, jsap_pkg::ERR_END);
    endcase
    phase = P_OPEN;
    hex_seen = 2'd0;
    code_acc = 16'd0;
  endfunction

  function void take_escape(input logic [7:0] c);
    phase = P_STR;
    case (c)
      CH_QUOTE:  queue_result(jsap_pkg::KIND_BYTE, CH_QUOTE, NO_ERR);
      CH_BSLASH: queue_result(jsap_pkg::KIND_BYTE, CH_BSLASH, NO_ERR);
      CH_SLASH:  queue_result(jsap_pkg::KIND_BYTE, CH_SLASH, NO_ERR);
      "b":       queue_result(jsap_pkg::KIND_BYTE, 8'h08, NO_ERR);
      "f":       queue_result(jsap_pkg::KIND_BYTE, 8'h0C, NO_ERR);
      "n":       queue_result(jsap_pkg::KIND_BYTE, 8'h0A, NO_ERR);
      "r":       queue_result(jsap_pkg::KIND_BYTE, 8'h0D, NO_ERR);
      "t":       queue_result(jsap_pkg::KIND_BYTE, 8'h09, NO_ERR);
      "u": begin
        phase = P_HEX;
        hex_seen = 2'd0;
        code_acc = 16'd0;
      end
      default:   enter_fail(jsap_pkg::ERR_ESCAPE);
    endcase
  endfunction

  function void take_hex(input logic [7:0] c);
    int         h;
    logic [3:0] nib;
    logic [15:0] v;
    h = hex_digit(c);
    if (h < 0) begin
      enter_fail(jsap_pkg::ERR_HEX);
    end else begin
      nib = h[3:0];
      code_acc = {code_acc[11:0], nib};
      if (hex_seen < 2'd3) begin
        hex_seen = hex_seen + 2'd1;
      end else begin
        v = code_acc;
        hex_seen = 2'd0;
        code_acc = 16'd0;
        phase = P_STR;
        emit_utf8(v);
      end
    end
  endfunction

  // one accepted request: advance the parser copy, queue its results
  function void decode_request(input logic op, input logic [7:0] c);
    jsap_pkg::res_t r;
    step_res.delete();
    if (op == jsap_pkg::OP_END) begin
      end_document();
    end else begin
      case (phase)
        P_OPEN: begin
          if (c == CH_LBRACK) phase = P_ITEM;
          else if (!is_blank(c)) enter_fail(jsap_pkg::ERR_OPEN);
        end
        P_ITEM: begin
          if (c == CH_RBRACK) phase = P_DONE;
          else if (c == CH_QUOTE) phase = P_STR;
          else if (!is_blank(c)) enter_fail(jsap_pkg::ERR_QUOTE);
        end
        P_STR: begin
          if (c == CH_QUOTE) begin
            phase = P_SEP;
            queue_result(jsap_pkg::KIND_ENTRY, 8'h00, NO_ERR);
          end else if (c == CH_BSLASH) begin
            phase = P_ESC;
          end else begin
            queue_result(jsap_pkg::KIND_BYTE, c, NO_ERR);
          end
        end
        P_ESC: take_escape(c);
        P_HEX: take_hex(c);
        P_SEP: begin
          if (c == CH_COMMA) phase = P_ITEM;
          else if (c == CH_RBRACK) phase = P_DONE;
          else if (!is_blank(c)) enter_fail(jsap_pkg::ERR_SEP);
        end
        P_DONE: begin
          if (!is_blank(c)) enter_fail(jsap_pkg::ERR_TRAILING);
        end
        default: ;
      endcase
    end
    foreach (step_res[i]) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      parse_due.insert(parse_due.size(), r);
    end
  endfunction

  function void check_result(input jsap_pkg::res_t got);
    jsap_pkg::res_t exp;
    if (parse_due.size() == 0) begin
      mismatches++;
      $display("%0t: expected no result, actual kind %0d byte %02h code %0d last %0d",
               $time, got.kind, got.data, got.error_code, got.last);
    end else begin
      exp = parse_due.pop_front();
      if (got.kind !== exp.kind) begin
        mismatches++;
        $display("%0t: kind expected %0d actual %0d", $time, exp.kind, got.kind);
      end
      if (got.data !== exp.data) begin
        mismatches++;
        $display("%0t: byte expected %02h actual %02h", $time, exp.data, got.data);
      end
      if (got.error_code !== exp.error_code) begin
        mismatches++;
        $display("%0t: error code expected %0d actual %0d", $time, exp.error_code,
                 got.error_code);
      end
      if (got.last !== exp.last) begin
        mismatches++;
        $display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
      end
    end
  endfunction

  // compare before predicting: a result never belongs to a request of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      phase = P_OPEN;
      hex_seen = 2'd0;
      code_acc = 16'd0;
      parse_due.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall)
        check_result({out_kind, out_out_byte, out_error_code, out_last});
      if (in_valid && !in_stall)
        decode_request(in_op, in_data_byte);
    end
    results_due = parse_due.size();
  end

endmodule

>>> tb/json_string_array_parser_test.sv
`timescale 1ns / 1ps

module json_string_array_parser_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_CYCLES  = 300;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_op;
  logic [7:0] in_data_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_out_byte;
  logic [3:0] out_error_code;
  logic       out_last;

  int mismatches;
  int results_due;
  int cycles = 0;
  int items_sent = 0;
  bit tx_fast = 1'b0;
  bit rx_fast = 1'b0;
  bit hold_off = 1'b0;

  logic [7:0] doc_bytes[$];
  string      esc_letters = "\"\\/bfnrt";

  json_string_array_parser u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_out_byte   (out_out_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

  json_string_array_parser_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_out_byte   (out_out_byte),
    .out_error_code (out_error_code),
    .out_last       (out_last),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one request; valid stays up across back-to-back requests
  task automatic push_request(input logic op, input logic [7:0] b);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_end();
    push_request(jsap_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_request(jsap_pkg::OP_BYTE, s[i]);
  endtask

  // sender idles until every predicted result is out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (results_due == 0);
    repeat (8) @(posedge clk);
  endtask

  // append one byte to the document
  function automatic void add_byte(input logic [7:0] b);
    doc_bytes.insert(doc_bytes.size(), b);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + {4'd0, v};
  endfunction

  function automatic void add_blank();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: add_byte(8'h20);
        1: add_byte(8'h09);
        2: add_byte(8'h0A);
        default: add_byte(8'h0D);
      endcase
    end
  endfunction

  // one string character: raw byte, short escape or \u with boundary bias
  function automatic void add_char();
    logic [7:0]  b;
    logic [15:0] cp;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      do b = 8'($urandom_range(0, 255)); while (b == "\"" || b == "\\");
      add_byte(b);
    end else if (pick < 7) begin
      add_byte("\\");
      add_byte(esc_letters[$urandom_range(0, 7)]);
    end else begin
      case ($urandom_range(0, 7))
        0: cp = 16'h0000;
        1: cp = 16'h007F;
        2: cp = 16'h0080;
        3: cp = 16'h07FF;
        4: cp = 16'h0800;
        5: cp = 16'hFFFF;
        6: cp = 16'hD800 | 16'($urandom_range(0, 16'h07FF));
        default: cp = 16'($urandom_range(0, 16'hFFFF));
      endcase
      add_byte("\\");
      add_byte("u");
      add_byte(hex_char(cp[15:12]));
      add_byte(hex_char(cp[11:8]));
      add_byte(hex_char(cp[7:4]));
      add_byte(hex_char(cp[3:0]));
    end
  endfunction

  function automatic void build_document();
    int n_str;
    int n_ch;
    doc_bytes.delete();
    add_blank();
    add_byte("[");
    n_str = $urandom_range(0, 3);
    for (int k = 0; k < n_str; k++) begin
      add_blank();
      add_byte("\"");
      n_ch = $urandom_range(0, 5);
      repeat (n_ch) add_char();
      add_byte("\"");
      add_blank();
      // separator, or now and then a trailing comma
      if (k < n_str - 1 || $urandom_range(0, 3) == 0) begin
        add_byte(",");
        add_blank();
      end
    end
    add_byte("]");
    add_blank();
  endfunction

  // break a well-formed document in one place
  function automatic void spoil_document();
    int pos;
    pos = $urandom_range(0, doc_bytes.size() - 1);
    case ($urandom_range(0, 3))
      0: doc_bytes[pos] = 8'($urandom_range(0, 255));
      1: while (doc_bytes.size() > pos) doc_bytes.delete(doc_bytes.size() - 1);
      2: add_byte(8'($urandom_range(0, 255)));
      default: doc_bytes.insert(pos, 8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void noise_document();
    doc_bytes.delete();
    if ($urandom_range(0, 1)) add_byte("[");
    repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
  endfunction

  // receiver: random stalls per result, long hold-offs on request
  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      n = rx_fast ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    int doc_n;
    int mode;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_op        = jsap_pkg::OP_BYTE;
    in_data_byte = 8'h00;
    out_stall    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: accept, bad open and repeat at end, end on the end item alone,
    // three-byte \u then unterminated, trailing content, bad hex digit
    send_text("[]");
    send_end();
    send_text("{");
    send_end();
    send_end();
    send_text("[\"\\uFfFf");
    send_end();
    send_text("[]x");
    send_end();
    send_text(" [\"\\u0g");
    send_end();
    settle();

    // random documents: mostly well-formed, some broken, some noise
    items_sent = 0;
    doc_n = 0;
    while (items_sent < RANDOM_ITEMS) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      if (doc_n == 3 || doc_n == 11) hold_off = 1'b1;
      if (doc_n == 7) settle();
      mode = $urandom_range(0, 19);
      if (mode < 14) begin
        build_document();
      end else if (mode < 17) begin
        build_document();
        spoil_document();
      end else begin
        noise_document();
      end
      foreach (doc_bytes[i]) push_request(jsap_pkg::OP_BYTE, doc_bytes[i]);
      send_end();
      doc_n++;
    end

    settle();
    if (mismatches == 0 && results_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
